// ===== rtl/slcd_pkg.sv =====
`timescale 1ns / 1ps

package slcd_pkg;

    localparam int HDR_LEN    = 7;
    localparam int HDR_IDX_W  = 3;
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDSHAKE_TYPE = 2'd3;

    localparam logic [7:0]  SYNC_FIRST_RST     = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST    = 8'h55;
    localparam logic [15:0] MAX_PAYLOAD_RST    = 16'd1014;
    localparam logic [7:0]  HANDSHAKE_TYPE_RST = 8'h00;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_HEADER,
        ST_PAYLOAD,
        ST_CHECK
    } parse_state_t;

    typedef struct packed {
        logic                 sel_rescan;
        logic [HDR_IDX_W-1:0] rescan_idx;
        logic                 hdr_start;
        logic                 hdr_write;
        logic                 load_len;
        logic                 payload_step;
        logic                 check_step;
    } dp_cmd_t;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic hdr_last;
        logic len_too_big;
        logic len_zero;
        logic rem_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/sync_length_checksum_deframer_unit.sv =====
`timescale 1ns / 1ps
// A payload byte or frame summary is registered and appears in the cycle after its input byte is taken.
// Throughput: one byte per cycle while the output register is free.
// An oversized length field stalls input while the stored header is rescanned.
// Reset (rst_n, asynchronous, active low) restores the default configuration,
// returns the parser to sync hunting and clears all counters; no clearing pass.
module sync_length_checksum_deframer_unit #(
    parameter int COUNTER_WIDTH = slcd_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [7:0]                       payload_byte,
    output logic [7:0]                       frame_type,
    output logic [7:0]                       frame_seq,
    output logic [15:0]                      slice_number,
    output logic [7:0]                       status_byte,
    output logic [15:0]                      payload_length,
    output logic                             sum_match,
    output logic                             seq_accept,
    output logic [31:0]                      frame_count,
    output logic [31:0]                      checksum_error_count,
    output logic [31:0]                      sequence_error_count
);

    slcd_pkg::dp_cmd_t    cmd;
    slcd_pkg::dp_status_t status;

    slcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    slcd_datapath #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .rx_byte              (rx_byte),
        .out_ready            (out_ready),
        .cmd                  (cmd),
        .status               (status),
        .out_valid            (out_valid),
        .kind                 (kind),
        .payload_byte         (payload_byte),
        .frame_type           (frame_type),
        .frame_seq            (frame_seq),
        .slice_number         (slice_number),
        .status_byte          (status_byte),
        .payload_length       (payload_length),
        .sum_match            (sum_match),
        .seq_accept           (seq_accept),
        .frame_count          (frame_count),
        .checksum_error_count (checksum_error_count),
        .sequence_error_count (sequence_error_count)
    );

endmodule

// ===== rtl/slcd_ctrl.sv =====
`timescale 1ns / 1ps

module slcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  slcd_pkg::dp_status_t status,
    output slcd_pkg::dp_cmd_t    cmd
);

    slcd_pkg::parse_state_t state_reg, state_next;
    logic                            rescan_reg, rescan_next;
    logic [slcd_pkg::HDR_IDX_W-1:0]  idx_reg, idx_next;
    logic                            accept;
    logic                            scan_valid;

    assign in_ready   = !rescan_reg && !status.out_busy;
    assign accept     = in_valid && in_ready;
    assign scan_valid = accept || rescan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= slcd_pkg::ST_HUNT;
            rescan_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rescan_reg <= rescan_next;
            idx_reg    <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        // The rescan walks the stored header bytes once, then input resumes.
        rescan_next = rescan_reg &&
                      (idx_reg != slcd_pkg::HDR_IDX_W'(slcd_pkg::HDR_LEN - 1));
        if (rescan_reg)
        begin
            idx_next = idx_reg + 1'b1;
        end

        cmd              = '0;
        cmd.sel_rescan   = rescan_reg;
        cmd.rescan_idx   = idx_reg;

        unique case (state_reg)
            slcd_pkg::ST_HUNT:
            begin
                if (scan_valid && status.is_sync1)
                begin
                    state_next = slcd_pkg::ST_SYNC2;
                end
            end
            slcd_pkg::ST_SYNC2:
            begin
                if (scan_valid)
                begin
                    if (status.is_sync2)
                    begin
                        state_next    = slcd_pkg::ST_HEADER;
                        cmd.hdr_start = 1'b1;
                    end
                    else if (!status.is_sync1)
                    begin
                        state_next = slcd_pkg::ST_HUNT;
                    end
                end
            end
            slcd_pkg::ST_HEADER:
            begin
                if (scan_valid)
                begin
                    cmd.hdr_write = 1'b1;
                    if (status.hdr_last)
                    begin
                        if (status.len_too_big)
                        begin
                            // Drop the sync pair and look again inside the header.
                            state_next  = slcd_pkg::ST_HUNT;
                            rescan_next = 1'b1;
                            idx_next    = '0;
                        end
                        else
                        begin
                            cmd.load_len = 1'b1;
                            state_next   = status.len_zero ? slcd_pkg::ST_CHECK
                                                           : slcd_pkg::ST_PAYLOAD;
                        end
                    end
                end
            end
            slcd_pkg::ST_PAYLOAD:
            begin
                if (accept)
                begin
                    cmd.payload_step = 1'b1;
                    if (status.rem_last)
                    begin
                        state_next = slcd_pkg::ST_CHECK;
                    end
                end
            end
            slcd_pkg::ST_CHECK:
            begin
                if (accept)
                begin
                    cmd.check_step = 1'b1;
                    state_next     = slcd_pkg::ST_HUNT;
                end
            end
            default:
            begin
                state_next = slcd_pkg::ST_HUNT;
            end
        endcase
    end

endmodule

// ===== rtl/slcd_datapath.sv =====
`timescale 1ns / 1ps

module slcd_datapath #(
    parameter int COUNTER_WIDTH = slcd_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]                       rx_byte,
    input  logic                             out_ready,
    input  slcd_pkg::dp_cmd_t                cmd,
    output slcd_pkg::dp_status_t             status,
    output logic                             out_valid,
    output logic                             kind,
    output logic [7:0]                       payload_byte,
    output logic [7:0]                       frame_type,
    output logic [7:0]                       frame_seq,
    output logic [15:0]                      slice_number,
    output logic [7:0]                       status_byte,
    output logic [15:0]                      payload_length,
    output logic                             sum_match,
    output logic                             seq_accept,
    output logic [31:0]                      frame_count,
    output logic [31:0]                      checksum_error_count,
    output logic [31:0]                      sequence_error_count
);

    logic [7:0]  sync1_reg;
    logic [7:0]  sync2_reg;
    logic [15:0] max_len_reg;
    logic [7:0]  hs_type_reg;

    logic [7:0]                      hdr_store_reg [slcd_pkg::HDR_LEN];
    logic [slcd_pkg::HDR_IDX_W-1:0]  fill_reg;
    logic [15:0]                     remain_reg;
    logic [7:0]                      sum_reg;
    logic [7:0]                      prev_seq_reg;
    logic                            have_prev_reg;
    logic [COUNTER_WIDTH-1:0]        frames_reg;
    logic [COUNTER_WIDTH-1:0]        ck_err_reg;
    logic [COUNTER_WIDTH-1:0]        sq_err_reg;

    logic       out_valid_reg;
    logic       kind_reg;
    logic [7:0] pbyte_reg;
    logic       ck_ok_reg;
    logic       sq_ok_reg;

    logic [7:0]  scan_byte;
    logic [15:0] len_now;
    logic        ck_ok;
    logic        type_match;
    logic        seq_next_ok;
    logic        sq_ok;

    assign scan_byte = cmd.sel_rescan ? hdr_store_reg[cmd.rescan_idx] : rx_byte;
    assign len_now   = {scan_byte, hdr_store_reg[5]};

    assign status.is_sync1    = (scan_byte == sync1_reg);
    assign status.is_sync2    = (scan_byte == sync2_reg);
    assign status.hdr_last    = (fill_reg == slcd_pkg::HDR_IDX_W'(slcd_pkg::HDR_LEN - 1));
    assign status.len_too_big = (len_now > max_len_reg);
    assign status.len_zero    = (len_now == 16'd0);
    assign status.rem_last    = (remain_reg == 16'd1);
    assign status.out_busy    = out_valid_reg && !out_ready;

    assign ck_ok       = (scan_byte == sum_reg);
    assign type_match  = (hdr_store_reg[0] == hs_type_reg);
    assign seq_next_ok = (hdr_store_reg[1] == prev_seq_reg + 8'd1);
    assign sq_ok       = ck_ok && (type_match || !have_prev_reg || seq_next_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync1_reg   <= slcd_pkg::SYNC_FIRST_RST;
            sync2_reg   <= slcd_pkg::SYNC_SECOND_RST;
            max_len_reg <= slcd_pkg::MAX_PAYLOAD_RST;
            hs_type_reg <= slcd_pkg::HANDSHAKE_TYPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slcd_pkg::CFG_SYNC_FIRST:     sync1_reg   <= cfg_data[7:0];
                slcd_pkg::CFG_SYNC_SECOND:    sync2_reg   <= cfg_data[7:0];
                slcd_pkg::CFG_MAX_PAYLOAD:    max_len_reg <= cfg_data;
                slcd_pkg::CFG_HANDSHAKE_TYPE: hs_type_reg <= cfg_data[7:0];
                default:                      sync1_reg   <= sync1_reg;
            endcase
        end
    end

    // Rescan writes only land below the read index, so no copy is needed.
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_write)
        begin
            hdr_store_reg[fill_reg] <= scan_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            remain_reg    <= '0;
            sum_reg       <= '0;
            prev_seq_reg  <= '0;
            have_prev_reg <= 1'b0;
            frames_reg    <= '0;
            ck_err_reg    <= '0;
            sq_err_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.hdr_start)
            begin
                fill_reg <= '0;
                sum_reg  <= '0;
            end
            else if (cmd.hdr_write)
            begin
                fill_reg <= status.hdr_last ? '0 : fill_reg + 1'b1;
                sum_reg  <= sum_reg + scan_byte;
            end
            else if (cmd.payload_step)
            begin
                sum_reg <= sum_reg + scan_byte;
            end

            if (cmd.load_len)
            begin
                remain_reg <= len_now;
            end
            else if (cmd.payload_step)
            begin
                remain_reg <= remain_reg - 16'd1;
            end

            if (cmd.check_step)
            begin
                frames_reg <= frames_reg + COUNTER_WIDTH'(1);
                if (!ck_ok)
                begin
                    ck_err_reg <= ck_err_reg + COUNTER_WIDTH'(1);
                end
                else if (!type_match)
                begin
                    prev_seq_reg  <= hdr_store_reg[1];
                    have_prev_reg <= 1'b1;
                    if (have_prev_reg && !seq_next_ok)
                    begin
                        sq_err_reg <= sq_err_reg + COUNTER_WIDTH'(1);
                    end
                end
            end

            if (cmd.payload_step || cmd.check_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.payload_step)
        begin
            kind_reg  <= slcd_pkg::KIND_PAYLOAD;
            pbyte_reg <= scan_byte;
            ck_ok_reg <= 1'b0;
            sq_ok_reg <= 1'b0;
        end
        else if (cmd.check_step)
        begin
            kind_reg  <= slcd_pkg::KIND_SUMMARY;
            pbyte_reg <= 8'd0;
            ck_ok_reg <= ck_ok;
            sq_ok_reg <= sq_ok;
        end
    end

    // Header and counters cannot change while a request waits at the output,
    // because no new byte is taken until it is gone.
    assign out_valid            = out_valid_reg;
    assign kind                 = kind_reg;
    assign payload_byte         = pbyte_reg;
    assign sum_match            = ck_ok_reg;
    assign seq_accept           = sq_ok_reg;
    assign frame_type           = hdr_store_reg[0];
    assign frame_seq            = hdr_store_reg[1];
    assign slice_number         = {hdr_store_reg[3], hdr_store_reg[2]};
    assign status_byte          = hdr_store_reg[4];
    assign payload_length       = {hdr_store_reg[6], hdr_store_reg[5]};
    assign frame_count          = 32'(frames_reg);
    assign checksum_error_count = 32'(ck_err_reg);
    assign sequence_error_count = 32'(sq_err_reg);

endmodule

// ===== rtl/slcd_checker.sv =====
`timescale 1ns / 1ps

module slcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic [7:0]  payload_byte,
    input logic        sum_match,
    input logic        seq_accept,
    input logic [31:0] frame_count
);

    // A stalled request keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte)
            && $stable(frame_count))
        else $error("output request changed while stalled");

    // Payload requests never carry verdict flags.
    a_payload_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == slcd_pkg::KIND_PAYLOAD) |-> !sum_match && !seq_accept)
        else $error("payload request carries a verdict flag");

    // A frame with a bad checksum cannot pass the sequence check.
    a_seq_needs_ck: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == slcd_pkg::KIND_SUMMARY) |-> sum_match || !seq_accept)
        else $error("sequence accepted on bad checksum");

    // A taken summary is not followed straight away by another request: the next frame needs sync first.
    a_summary_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind == slcd_pkg::KIND_SUMMARY) |=> !out_valid)
        else $error("request right after a frame summary");

endmodule

bind sync_length_checksum_deframer_unit slcd_checker u_slcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .sum_match    (sum_match),
    .seq_accept   (seq_accept),
    .frame_count  (frame_count)
);
